// ===== rtl/core/xpf_pkg.sv =====
package xpf_pkg;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Configuration register indexes
  localparam logic CFG_CHUNK_BYTES      = 1'b0;
  localparam logic CFG_CHUNKS_PER_GROUP = 1'b1;

  // Configuration reset values
  localparam logic [5:0] CHUNK_BYTES_RST      = 6'd32;
  localparam logic [7:0] CHUNKS_PER_GROUP_RST = 8'd4;

  // Operation on the parity store in a given cycle
  typedef struct packed {
    logic xor_en;  // fold the incoming byte into the addressed entry
    logic clr;     // clear every entry
  } store_op_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic draining;
    logic data_load;
  } seq_status_t;

endpackage

// ===== rtl/core/xpf_store.sv =====
module xpf_store #(
  parameter int MAX_CHUNK_BYTES = 32,
  parameter int PW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  xpf_pkg::store_op_t  op,
  input  logic [PW-1:0]       idx,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata
);

  logic [7:0] store [MAX_CHUNK_BYTES];

  // Single XOR unit shared by every position; clear wipes all entries
  always_ff @(posedge clk) begin
    if (rst || op.clr) begin
      for (int i = 0; i < MAX_CHUNK_BYTES; i++) begin
        store[i] <= 8'd0;
      end
    end else if (op.xor_en) begin
      store[idx] <= store[idx] ^ wdata;
    end
  end

  assign rdata = store[idx];

endmodule

// ===== rtl/core/xpf_seq.sv =====
module xpf_seq #(
  parameter int MAX_CHUNK_BYTES = 32,
  parameter int PW = 5,
  parameter int SW = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic [5:0]              chunk_bytes,
  input  logic [7:0]              chunks_per_group,
  // input item
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              data_byte,
  input  logic                    payload_last,
  // result item
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    is_parity,
  output logic                    chunk_end,
  output logic                    payload_done,
  output logic                    run_last,
  // parity store access
  output xpf_pkg::store_op_t      op,
  output logic [PW-1:0]           store_idx,
  input  logic [7:0]              store_rdata,
  output xpf_pkg::seq_status_t    status
);

  xpf_pkg::state_t state, state_next;

  logic [PW-1:0] pos, pos_next;
  logic [7:0]    cig, cig_next;
  logic [PW-1:0] idx, idx_next;
  logic [SW-1:0] dsize, dsize_next;
  logic          dlast, dlast_next;

  logic          out_valid_next;
  logic [7:0]    out_byte_next;
  logic          is_parity_next, chunk_end_next, payload_done_next, run_last_next;

  logic [SW-1:0] size_c;
  logic [7:0]    group_c;
  logic          out_free, chunk_done, grp_done, emit, drain_end;

  // Clamp configuration into the legal ranges
  always_comb begin
    if (chunk_bytes == 6'd0) begin
      size_c = SW'(1);
    end else if (chunk_bytes > 6'(MAX_CHUNK_BYTES)) begin
      size_c = SW'(MAX_CHUNK_BYTES);
    end else begin
      size_c = chunk_bytes[SW-1:0];
    end
    group_c = (chunks_per_group == 8'd0) ? 8'd1 : chunks_per_group;
  end

  // Chunk and group boundary decisions for the current byte
  assign out_free   = !out_valid || !out_stall;
  assign chunk_done = payload_last || (7'(pos) + 7'd1 >= 7'(size_c));
  assign grp_done   = chunk_done && ({1'b0, cig} + 9'd1 >= {1'b0, group_c});
  assign emit       = chunk_done && (grp_done || payload_last);
  assign drain_end  = (7'(idx) + 7'd1 == 7'(dsize));

  // Next state and outputs
  always_comb begin
    state_next        = state;
    pos_next          = pos;
    cig_next          = cig;
    idx_next          = idx;
    dsize_next        = dsize;
    dlast_next        = dlast;
    out_valid_next    = out_valid && out_stall;
    out_byte_next     = out_byte;
    is_parity_next    = is_parity;
    chunk_end_next    = chunk_end;
    payload_done_next = payload_done;
    run_last_next     = run_last;
    op                = '0;
    in_stall          = 1'b1;
    store_idx         = pos;
    status            = '0;
    unique case (state)
      xpf_pkg::ST_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          status.data_load  = 1'b1;
          op.xor_en         = 1'b1;
          out_valid_next    = 1'b1;
          out_byte_next     = data_byte;
          is_parity_next    = 1'b0;
          chunk_end_next    = chunk_done;
          payload_done_next = 1'b0;
          run_last_next     = !emit;
          if (!chunk_done) begin
            pos_next = pos + PW'(1);
          end else begin
            pos_next = '0;
            cig_next = emit ? 8'd0 : cig + 8'd1;
          end
          if (emit) begin
            state_next = xpf_pkg::ST_DRAIN;
            idx_next   = '0;
            dsize_next = size_c;
            dlast_next = payload_last;
          end
        end
      end
      xpf_pkg::ST_DRAIN: begin
        status.draining = 1'b1;
        store_idx       = idx;
        if (out_free) begin
          out_valid_next    = 1'b1;
          out_byte_next     = store_rdata;
          is_parity_next    = 1'b1;
          chunk_end_next    = drain_end;
          payload_done_next = drain_end && dlast;
          run_last_next     = drain_end;
          if (drain_end) begin
            op.clr     = 1'b1;
            state_next = xpf_pkg::ST_IDLE;
          end else begin
            idx_next = idx + PW'(1);
          end
        end
      end
      default: state_next = xpf_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xpf_pkg::ST_IDLE;
      pos       <= '0;
      cig       <= 8'd0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      cig       <= cig_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dsize        <= dsize_next;
    dlast        <= dlast_next;
    out_byte     <= out_byte_next;
    is_parity    <= is_parity_next;
    chunk_end    <= chunk_end_next;
    payload_done <= payload_done_next;
    run_last     <= run_last_next;
  end

endmodule

// ===== rtl/core/xor_parity_fec_chunker_unit.sv =====
// XOR parity FEC chunker.
// Input channel (in_valid / in_stall): one payload byte per item, with
// payload_last on the final byte. Every byte goes out as a data item, with
// chunk_end on the last byte of each chunk. After chunks_per_group chunks,
// or at the end of the payload, a parity chunk of chunk_bytes items (clamped to 1..MAX_CHUNK_BYTES) follows;
// payload_done marks its last byte at the end of a payload, run_last marks
// the last item caused by one input byte.
// Output channel (out_valid / out_stall): one registered result stage.
// Config channel (cfg_valid / cfg_ready): index 0 chunk_bytes, index 1
// chunks_per_group; always ready, write only while idle.
// The data item is registered and appears in the cycle after the byte is taken.
// One byte is taken per cycle while no parity is due and the output does not
// stall; a parity drain reads one store entry per cycle, with input held off.
// A stall on the output holds the result register and the sequencer.
// Reset clears the parity store, counters and output valid, and sets
// chunk_bytes to 32 and chunks_per_group to 4.
module xor_parity_fec_chunker_unit #(
  parameter int MAX_CHUNK_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       payload_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_parity,
  output logic       chunk_end,
  output logic       payload_done,
  output logic       run_last
);

  localparam int PW = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
  localparam int SW = $clog2(MAX_CHUNK_BYTES + 1);

  logic [5:0] chunk_bytes;
  logic [7:0] chunks_per_group;

  xpf_pkg::store_op_t   op;
  xpf_pkg::seq_status_t status;
  logic [PW-1:0]        store_idx;
  logic [7:0]           store_rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes      <= xpf_pkg::CHUNK_BYTES_RST;
      chunks_per_group <= xpf_pkg::CHUNKS_PER_GROUP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        xpf_pkg::CFG_CHUNK_BYTES:      chunk_bytes      <= cfg_data[5:0];
        xpf_pkg::CFG_CHUNKS_PER_GROUP: chunks_per_group <= cfg_data;
        default: ;
      endcase
    end
  end

  xpf_seq #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
    .PW              (PW),
    .SW              (SW)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .chunk_bytes      (chunk_bytes),
    .chunks_per_group (chunks_per_group),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .payload_last     (payload_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .is_parity        (is_parity),
    .chunk_end        (chunk_end),
    .payload_done     (payload_done),
    .run_last         (run_last),
    .op               (op),
    .store_idx        (store_idx),
    .store_rdata      (store_rdata),
    .status           (status)
  );

  xpf_store #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
    .PW              (PW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .idx   (store_idx),
    .wdata (data_byte),
    .rdata (store_rdata)
  );

  // A taken byte always shows up as a data item in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    status.data_load |=> (out_valid && !is_parity))
    else $error("taken byte not presented as data item");

  // No byte is taken while the parity chunk drains
  assert property (@(posedge clk) disable iff (rst)
    status.draining |-> in_stall)
    else $error("input accepted during parity drain");

  // End of payload is only flagged on the closing parity byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_done) |-> (is_parity && chunk_end && run_last))
    else $error("payload_done on a non-final item");

  // Bytes are only folded into the parity store from the idle state
  assert property (@(posedge clk) disable iff (rst)
    op.xor_en |-> !status.draining)
    else $error("parity update during drain");

endmodule
